FILE: rtl/wpa_rsn_ie_security_parser_defines.svh
// Assertion macros shared by the parser's RTL files.
`ifndef WPA_RSN_IE_SECURITY_PARSER_DEFINES_SVH
`define WPA_RSN_IE_SECURITY_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define WRSP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define WRSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/wrsp_pkg.sv
// Types, codes and suite tables for the RSN/WPA element parser.
package wrsp_pkg;

  localparam logic [7:0] ID_RSN    = 8'h30;
  localparam logic [7:0] ID_VENDOR = 8'hdd;
  localparam logic [7:0] WPA_TYPE  = 8'h01;
  localparam logic [7:0] AKM_DOT1X = 8'h01;

  localparam logic [7:0] SUITE_WEP40  = 8'h01;
  localparam logic [7:0] SUITE_TKIP   = 8'h02;
  localparam logic [7:0] SUITE_WRAP   = 8'h03;
  localparam logic [7:0] SUITE_CCMP   = 8'h04;
  localparam logic [7:0] SUITE_WEP104 = 8'h05;

  localparam logic [2:0] SEC_WPA2  = 3'h1;
  localparam logic [2:0] SEC_WPA   = 3'h2;
  localparam logic [2:0] SEC_DOT1X = 3'h4;

  localparam logic [4:0] CIPH_TKIP   = 5'h01;
  localparam logic [4:0] CIPH_CCMP   = 5'h02;
  localparam logic [4:0] CIPH_WEP40  = 5'h04;
  localparam logic [4:0] CIPH_WEP104 = 5'h08;
  localparam logic [4:0] CIPH_WRAP   = 5'h10;

  typedef enum logic [10:0] {
    PH_ID     = 11'b000_0000_0001,
    PH_LEN    = 11'b000_0000_0010,
    PH_WOUI   = 11'b000_0000_0100,
    PH_WTYPE  = 11'b000_0000_1000,
    PH_VER    = 11'b000_0001_0000,
    PH_GROUP  = 11'b000_0010_0000,
    PH_PCOUNT = 11'b000_0100_0000,
    PH_PLIST  = 11'b000_1000_0000,
    PH_ACOUNT = 11'b001_0000_0000,
    PH_ALIST  = 11'b010_0000_0000,
    PH_SKIP   = 11'b100_0000_0000
  } phase_t;

  typedef enum logic [1:0] {
    KIND_SKIP = 2'd0,
    KIND_RSN  = 2'd1,
    KIND_WPA  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] data;
    logic       new_cell;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [4:0] cip;
    logic [2:0] sec;
  } flags_t;

  function automatic logic [7:0] wpa_oui_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h00;
      2'd1:    b = 8'h50;
      2'd2:    b = 8'hf2;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] rsn_oui_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h00;
      2'd1:    b = 8'h0f;
      2'd2:    b = 8'hac;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [4:0] cipher_bit(input logic [7:0] suite);
    logic [4:0] c;
    case (suite)
      SUITE_WEP40:  c = CIPH_WEP40;
      SUITE_TKIP:   c = CIPH_TKIP;
      SUITE_WRAP:   c = CIPH_WRAP;
      SUITE_CCMP:   c = CIPH_CCMP;
      SUITE_WEP104: c = CIPH_WEP104;
      default:      c = 5'h00;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/wpa_rsn_ie_security_parser.sv
// Top level of the RSN/WPA information element security parser.
//
//  channel | dir | handshake             | content
//  --------+-----+-----------------------+-------------------------------------------
//  in_     | in  | in_tvalid/in_tready   | one element buffer byte, tlast = buffer end
//  out_    | out | out_tvalid/out_tready | security summary, one per buffer end
//
// One byte a cycle unless a waiting summary holds a tlast byte; each byte is
// registered, decoded combinationally, and its summary, if any, lands in the output register.
// rst_n is synchronous: the walk returns to awaiting an id and all flags clear.
// A summary waiting on out_tready holds only bytes that carry tlast; other
// bytes keep flowing past it.
`include "wpa_rsn_ie_security_parser_defines.svh"

module wpa_rsn_ie_security_parser
  import wrsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic [0:0] in_tuser,   // [0] new_cell
  input  logic       in_tlast,   // buffer_end
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] wpa_seen, [1] wpa2_seen, [2] dot1x_seen,
                                 // [3] cipher_tkip, [4] cipher_ccmp,
                                 // [5] cipher_wep40, [6] cipher_wep104, [7] cipher_wrap
);

  item_t      in_item;
  item_t      item;
  logic       item_valid;
  logic       adv;
  flags_t     flags_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_data_r;

  assign in_item = '{data: in_tdata, new_cell: in_tuser[0], last: in_tlast};

  wrsp_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .adv        (adv),
    .item_valid (item_valid),
    .item       (item)
  );

  wrsp_walker u_walker (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd       (adv),
    .item      (item),
    .flags_nxt (flags_nxt)
  );

  // advance unless a summary would overwrite one still waiting
  assign adv = item_valid && (!item.last || !out_valid_r || out_tready);

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if (adv && item.last) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && item.last) begin
      out_data_r <= {flags_nxt.cip, flags_nxt.sec[2], flags_nxt.sec[0], flags_nxt.sec[1]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `WRSP_ASSERT_SAME(a_out_rise_from_last, $rose(out_valid_r), $past(adv && item.last), "summary without a buffer end")
  `WRSP_ASSERT_SAME(a_no_overwrite, out_valid_r && !out_tready, !(adv && item.last), "waiting summary overwritten")
  `WRSP_ASSERT_NEXT(a_plain_byte_flows, item_valid && !item.last, !$past(item_valid && !adv), "plain byte stalled")

endmodule

FILE: rtl/wrsp_in_stage.sv
// Input register for incoming element buffer bytes.
module wrsp_in_stage
  import wrsp_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  input  logic  adv,
  output logic  item_valid,
  output item_t item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  assign in_ready   = !valid_r || adv;
  assign valid_nxt  = in_ready ? in_valid : valid_r;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload loads on every request taken
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

FILE: rtl/wrsp_walker.sv
// Element walker: per-byte next-state logic and the walk and flag registers.
`include "wpa_rsn_ie_security_parser_defines.svh"

module wrsp_walker
  import wrsp_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   upd,
  input  item_t  item,
  output flags_t flags_nxt
);

  logic [8:0]  pos_r, pos_nxt;
  logic [7:0]  len_r, len_nxt;
  kind_t       kind_r, kind_nxt;
  phase_t      phase_r, phase_nxt;
  logic [15:0] left_r, left_nxt;
  logic        match_r, match_nxt;
  logic [7:0]  low_r, low_nxt;
  logic [2:0]  sec_r, sec_nxt;
  logic [4:0]  cip_r, cip_nxt;
  logic [4:0]  pcip_r, pcip_nxt;
  logic        pdot_r, pdot_nxt;
  logic [1:0]  sub_r, sub_nxt;

  logic [7:0]  d;
  logic [2:0]  sec_base;
  logic [4:0]  cip_base;
  logic        is_rsn;
  logic [8:0]  ver_end;
  logic [8:0]  grp_end;
  logic [7:0]  oui_byte;
  logic        suite_done;
  logic [15:0] left_dec;
  logic [15:0] count_val;
  logic [4:0]  pend_cip;
  logic        pend_dot;
  logic [7:0]  len_eff;
  logic        end_hit;

  always_comb begin
    d          = item.data;
    sec_base   = item.new_cell ? 3'h0 : sec_r;
    cip_base   = item.new_cell ? 5'h00 : cip_r;
    is_rsn     = (kind_r == KIND_RSN);
    ver_end    = is_rsn ? 9'd3 : 9'd7;
    grp_end    = is_rsn ? 9'd7 : 9'd11;
    oui_byte   = is_rsn ? rsn_oui_byte(sub_r) : wpa_oui_byte(sub_r);
    suite_done = (sub_r == 2'd3);
    left_dec   = (left_r != 16'd0) ? 16'(left_r - 16'd1) : left_r;
    count_val  = {d, low_r};
    pend_cip   = pcip_r | ((match_r && suite_done) ? cipher_bit(d) : 5'h00);
    pend_dot   = pdot_r | (match_r && suite_done && (d == AKM_DOT1X));

    pos_nxt   = pos_r;
    len_nxt   = len_r;
    kind_nxt  = kind_r;
    phase_nxt = phase_r;
    left_nxt  = left_r;
    match_nxt = match_r;
    low_nxt   = low_r;
    sec_nxt   = sec_base;
    cip_nxt   = cip_base;
    pcip_nxt  = pcip_r;
    pdot_nxt  = pdot_r;
    sub_nxt   = sub_r;

    unique case (phase_r)
      PH_ID: begin
        if (d == ID_RSN) begin
          kind_nxt = KIND_RSN;
        end else if (d == ID_VENDOR) begin
          kind_nxt = KIND_WPA;
        end else begin
          kind_nxt = KIND_SKIP;
        end
        phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        len_nxt = d;
        if (kind_r == KIND_RSN) begin
          phase_nxt = PH_VER;
        end else if (kind_r == KIND_WPA) begin
          phase_nxt = PH_WOUI;
        end else begin
          phase_nxt = PH_SKIP;
        end
      end
      PH_WOUI: begin
        if (pos_r < 9'd2 || pos_r > 9'd4 ||
            d != wpa_oui_byte(2'(pos_r[1:0] - 2'd2))) begin
          kind_nxt  = KIND_SKIP;
          phase_nxt = PH_SKIP;
        end else if (pos_r == 9'd4) begin
          phase_nxt = PH_WTYPE;
        end
      end
      PH_WTYPE: begin
        if (d == WPA_TYPE) begin
          phase_nxt = PH_VER;
        end else begin
          kind_nxt  = KIND_SKIP;
          phase_nxt = PH_SKIP;
        end
      end
      PH_VER: begin
        if (pos_r == ver_end) begin
          sec_nxt   = sec_base | (is_rsn ? SEC_WPA2 : SEC_WPA);
          phase_nxt = PH_GROUP;
        end
      end
      PH_GROUP: begin
        if (pos_r == grp_end) begin
          phase_nxt = PH_PCOUNT;
          sub_nxt   = 2'd0;
        end
      end
      PH_PCOUNT: begin
        if (sub_r == 2'd0) begin
          low_nxt = d;
          sub_nxt = 2'd1;
        end else begin
          left_nxt  = count_val;
          sub_nxt   = 2'd0;
          pcip_nxt  = 5'h00;
          phase_nxt = (count_val == 16'd0) ? PH_ACOUNT : PH_PLIST;
        end
      end
      PH_PLIST: begin
        if (!suite_done) begin
          match_nxt = ((sub_r == 2'd0) || match_r) && (d == oui_byte);
          sub_nxt   = 2'(sub_r + 2'd1);
        end else begin
          sub_nxt  = 2'd0;
          left_nxt = left_dec;
          if (left_dec == 16'd0) begin
            cip_nxt   = cip_base | pend_cip;
            pcip_nxt  = 5'h00;
            phase_nxt = PH_ACOUNT;
          end else begin
            pcip_nxt = pend_cip;
          end
        end
      end
      PH_ACOUNT: begin
        if (sub_r == 2'd0) begin
          low_nxt = d;
          sub_nxt = 2'd1;
        end else begin
          left_nxt  = count_val;
          sub_nxt   = 2'd0;
          pdot_nxt  = 1'b0;
          phase_nxt = (count_val == 16'd0) ? PH_SKIP : PH_ALIST;
        end
      end
      PH_ALIST: begin
        if (!suite_done) begin
          match_nxt = ((sub_r == 2'd0) || match_r) && (d == oui_byte);
          sub_nxt   = 2'(sub_r + 2'd1);
        end else begin
          sub_nxt  = 2'd0;
          left_nxt = left_dec;
          if (left_dec == 16'd0) begin
            if (pend_dot) begin
              sec_nxt = sec_base | SEC_DOT1X;
            end
            pdot_nxt  = 1'b0;
            phase_nxt = PH_SKIP;
          end else begin
            pdot_nxt = pend_dot;
          end
        end
      end
      PH_SKIP: begin
      end
      default: begin
      end
    endcase

    // element ends on its last declared byte or at buffer end
    len_eff = (phase_r == PH_LEN) ? d : len_r;
    end_hit = ((pos_r != 9'd0) && (pos_r == 9'({1'b0, len_eff} + 9'd1))) || item.last;

    if (end_hit) begin
      // assume TKIP when the element stops after its version but before the pairwise count is complete
      if (kind_nxt != KIND_SKIP && (phase_nxt == PH_GROUP || phase_nxt == PH_PCOUNT)) begin
        cip_nxt = cip_nxt | CIPH_TKIP;
      end
      pos_nxt   = 9'd0;
      len_nxt   = 8'd0;
      kind_nxt  = KIND_SKIP;
      phase_nxt = PH_ID;
      left_nxt  = 16'd0;
      match_nxt = 1'b1;
      low_nxt   = 8'd0;
      pcip_nxt  = 5'h00;
      pdot_nxt  = 1'b0;
      sub_nxt   = 2'd0;
    end else begin
      pos_nxt = 9'(pos_r + 9'd1);
    end
  end

  assign flags_nxt = '{cip: cip_nxt, sec: sec_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= 9'd0;
      len_r   <= 8'd0;
      kind_r  <= KIND_SKIP;
      phase_r <= PH_ID;
      left_r  <= 16'd0;
      match_r <= 1'b1;
      low_r   <= 8'd0;
      sec_r   <= 3'h0;
      cip_r   <= 5'h00;
      pcip_r  <= 5'h00;
      pdot_r  <= 1'b0;
      sub_r   <= 2'd0;
    end else if (upd) begin
      pos_r   <= pos_nxt;
      len_r   <= len_nxt;
      kind_r  <= kind_nxt;
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      match_r <= match_nxt;
      low_r   <= low_nxt;
      sec_r   <= sec_nxt;
      cip_r   <= cip_nxt;
      pcip_r  <= pcip_nxt;
      pdot_r  <= pdot_nxt;
      sub_r   <= sub_nxt;
    end
  end

  `WRSP_ASSERT_SAME(a_id_at_start, 1'b1, (phase_r == PH_ID) == (pos_r == 9'd0), "walk position and id phase disagree")
  `WRSP_ASSERT_SAME(a_skip_kind_phase, kind_r == KIND_SKIP, phase_r == PH_ID || phase_r == PH_LEN || phase_r == PH_SKIP, "skipped element in a decode phase")
  `WRSP_ASSERT_NEXT(a_end_resets_walk, upd && item.last, phase_r == PH_ID && pos_r == 9'd0, "walk not reset after buffer end")

endmodule
